/* rtl/arp_responder_with_cache_unit_macros.svh */
// Assertion macros for the ARP responder with cache; they use clk and rst of the enclosing scope.
`ifndef ARP_RESPONDER_WITH_CACHE_UNIT_MACROS_SVH
`define ARP_RESPONDER_WITH_CACHE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition in the same cycle as its trigger.
`define ARPC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arpc assertion failed");
// Check a condition in the cycle after its trigger.
`define ARPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arpc assertion failed");
`else
`define ARPC_ASSERT(lbl, ante, cons)
`define ARPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/arpc_pkg.sv */
// Shared constants, codes and types of the ARP responder with cache.
package arpc_pkg;

  // Cache geometry
  localparam int CACHE_ENTRIES = 128;
  localparam int ADDR_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int IP_W = 32;
  localparam int MAC_W = 48;
  localparam int LEN_W = 11;
  localparam int WORD_W = 16;
  localparam int BYTE_W = 8;
  localparam int STATUS_W = 3;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'd1;

  // Protocol words, byte-swapped as stored
  localparam logic [LEN_W-1:0] MIN_PAYLOAD = 11'd28;
  localparam logic [WORD_W-1:0] HW_ETHERNET = 16'h0100;
  localparam logic [WORD_W-1:0] PROTO_IPV4 = 16'h0008;
  localparam logic [BYTE_W-1:0] HW_LEN_ETH = 8'd6;
  localparam logic [BYTE_W-1:0] PROTO_LEN_IPV4 = 8'd4;
  localparam logic [WORD_W-1:0] OP_REQUEST = 16'h0100;
  localparam logic [WORD_W-1:0] OP_REPLY = 16'h0200;
  localparam logic [MAC_W-1:0] MAC_ALL_ONES = 48'hFFFF_FFFF_FFFF;

  localparam logic CMD_RECEIVE = 1'b0;
  localparam logic CMD_RESOLVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED = 3'd0,
    ST_REPLIED = 3'd1,
    ST_CACHED  = 3'd2,
    ST_FULL    = 3'd3,
    ST_HIT     = 3'd4,
    ST_MISS    = 3'd5
  } status_e_t;

  // Work classes decided by the front
  typedef enum logic [1:0] {
    K_IGNORE,
    K_REPLY,
    K_CACHE,
    K_RESOLVE
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } job_t;

  typedef struct packed {
    status_e_t         status;
    logic              send_valid;
    logic [WORD_W-1:0] opcode;
    logic [MAC_W-1:0]  sender_mac;
    logic [IP_W-1:0]   sender_ip;
    logic [MAC_W-1:0]  target_mac;
    logic [IP_W-1:0]   target_ip;
    logic [MAC_W-1:0]  lookup_mac;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } back_state_t;

  typedef struct packed {
    logic              scanning;
    logic [CNT_W-1:0]  entry_count;
    logic [ADDR_W-1:0] scan_addr;
  } back_stat_t;

endpackage

/* rtl/arpc_ifs.sv */
// Valid/ready channel interfaces for ARP items and ARP results.
interface arpc_in_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic [arpc_pkg::LEN_W-1:0]       payload_length;
  logic [arpc_pkg::WORD_W-1:0]      hw_type;
  logic [arpc_pkg::WORD_W-1:0]      proto_type;
  logic [arpc_pkg::BYTE_W-1:0]      hw_addr_len;
  logic [arpc_pkg::BYTE_W-1:0]      proto_addr_len;
  logic [arpc_pkg::WORD_W-1:0]      opcode;
  logic [arpc_pkg::MAC_W-1:0]       sender_mac;
  logic [arpc_pkg::IP_W-1:0]        sender_ip;
  logic [arpc_pkg::MAC_W-1:0]       target_mac;
  logic [arpc_pkg::IP_W-1:0]        target_ip;
  logic [arpc_pkg::IP_W-1:0]        query_ip;

  modport source (
    output valid, command, payload_length, hw_type, proto_type, hw_addr_len,
           proto_addr_len, opcode, sender_mac, sender_ip, target_mac, target_ip,
           query_ip,
    input  ready
  );
  modport sink (
    input  valid, command, payload_length, hw_type, proto_type, hw_addr_len,
           proto_addr_len, opcode, sender_mac, sender_ip, target_mac, target_ip,
           query_ip,
    output ready
  );
endinterface

interface arpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [arpc_pkg::STATUS_W-1:0] status;
  logic                          send_valid;
  logic [arpc_pkg::WORD_W-1:0]   out_opcode;
  logic [arpc_pkg::MAC_W-1:0]    out_sender_mac;
  logic [arpc_pkg::IP_W-1:0]     out_sender_ip;
  logic [arpc_pkg::MAC_W-1:0]    out_target_mac;
  logic [arpc_pkg::IP_W-1:0]     out_target_ip;
  logic [arpc_pkg::MAC_W-1:0]    lookup_mac;

  modport source (
    output valid, status, send_valid, out_opcode, out_sender_mac, out_sender_ip,
           out_target_mac, out_target_ip, lookup_mac,
    input  ready
  );
  modport sink (
    input  valid, status, send_valid, out_opcode, out_sender_mac, out_sender_ip,
           out_target_mac, out_target_ip, lookup_mac,
    output ready
  );
endinterface

/* rtl/arpc_front.sv */
// Front end: accepts ARP items, validates received messages and classifies the work.
module arpc_front (
  input  logic [arpc_pkg::IP_W-1:0] own_ip,
  arpc_in_if.sink                   req,
  output logic                      push_valid,
  input  logic                      push_ready,
  output arpc_pkg::job_t            push_job
);

  logic msg_ok;

  // Accept whenever the queue has room
  assign req.ready = push_ready;
  assign push_valid = req.valid;

  // Check the message header and the target address
  assign msg_ok = (req.payload_length >= arpc_pkg::MIN_PAYLOAD) &&
                  (req.hw_type == arpc_pkg::HW_ETHERNET) &&
                  (req.proto_type == arpc_pkg::PROTO_IPV4) &&
                  (req.hw_addr_len == arpc_pkg::HW_LEN_ETH) &&
                  (req.proto_addr_len == arpc_pkg::PROTO_LEN_IPV4) &&
                  (req.target_ip == own_ip);

  // Classify into a job for the back end
  always_comb begin
    push_job.ip = req.sender_ip;
    push_job.mac = req.sender_mac;
    push_job.kind = arpc_pkg::K_IGNORE;
    if (req.command == arpc_pkg::CMD_RESOLVE) begin
      push_job.kind = arpc_pkg::K_RESOLVE;
      push_job.ip = req.query_ip;
    end else if (msg_ok && req.opcode == arpc_pkg::OP_REQUEST) begin
      push_job.kind = arpc_pkg::K_REPLY;
    end else if (msg_ok && req.opcode == arpc_pkg::OP_REPLY) begin
      push_job.kind = arpc_pkg::K_CACHE;
    end
  end

endmodule

/* rtl/arpc_queue.sv */
// Short job queue between the front end and the back end.
module arpc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  arpc_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output arpc_pkg::job_t pop_job
);

  arpc_pkg::job_t                   slots [arpc_pkg::QUEUE_DEPTH];
  logic [arpc_pkg::QPTR_W-1:0]      wr_ptr;
  logic [arpc_pkg::QPTR_W-1:0]      rd_ptr;
  logic [arpc_pkg::QCNT_W-1:0]      fill;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = (fill != arpc_pkg::QCNT_W'(arpc_pkg::QUEUE_DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_job = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == arpc_pkg::QPTR_W'(arpc_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + arpc_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == arpc_pkg::QPTR_W'(arpc_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + arpc_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + arpc_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - arpc_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

/* rtl/arpc_back.sv */
// Back end: carries out jobs against the address cache and holds the result register.
module arpc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [arpc_pkg::IP_W-1:0]  own_ip,
  input  logic [arpc_pkg::MAC_W-1:0] own_mac,
  input  logic                       job_valid,
  output logic                       job_ready,
  input  arpc_pkg::job_t             job,
  arpc_out_if.source                 rsp,
  output arpc_pkg::back_stat_t       stat
);

  // Cache storage
  logic [arpc_pkg::IP_W-1:0]   ip_mem  [arpc_pkg::CACHE_ENTRIES];
  logic [arpc_pkg::MAC_W-1:0]  mac_mem [arpc_pkg::CACHE_ENTRIES];

  arpc_pkg::back_state_t       state;
  arpc_pkg::back_state_t       state_next;
  logic [arpc_pkg::CNT_W-1:0]  entry_count;
  logic [arpc_pkg::ADDR_W-1:0] scan_addr;
  logic [arpc_pkg::IP_W-1:0]   query;
  logic [arpc_pkg::IP_W-1:0]   rd_ip;
  logic [arpc_pkg::MAC_W-1:0]  rd_mac;
  logic                        rd_valid;
  logic                        out_valid;
  arpc_pkg::result_t           res;
  arpc_pkg::result_t           res_next;

  logic                        out_free;
  logic                        pop;
  logic                        has_room;
  logic                        cache_we;
  logic                        start_scan;
  logic                        hit_now;
  logic                        scan_last;
  logic                        load;
  logic [arpc_pkg::MAC_W-1:0]  found_mac;
  logic [arpc_pkg::IP_W-1:0]   res_query;

  assign out_free = !out_valid || rsp.ready;
  assign pop = (state == arpc_pkg::S_IDLE) && job_valid && out_free;
  assign job_ready = (state == arpc_pkg::S_IDLE) && out_free;
  assign has_room = (entry_count < arpc_pkg::CNT_W'(arpc_pkg::CACHE_ENTRIES));
  assign cache_we = pop && (job.kind == arpc_pkg::K_CACHE) && has_room;
  assign start_scan = pop && (job.kind == arpc_pkg::K_RESOLVE) && (entry_count != '0);
  assign hit_now = rd_valid && (rd_ip == query);
  assign scan_last = (arpc_pkg::CNT_W'(scan_addr) == entry_count - arpc_pkg::CNT_W'(1));
  assign load = (pop && !start_scan) ||
                (state == arpc_pkg::S_SCAN && hit_now) ||
                (state == arpc_pkg::S_DRAIN);

  // Append to the cache and read one entry a cycle during a scan
  always_ff @(posedge clk) begin
    if (cache_we) begin
      ip_mem[entry_count[arpc_pkg::ADDR_W-1:0]] <= job.ip;
      mac_mem[entry_count[arpc_pkg::ADDR_W-1:0]] <= job.mac;
    end
    rd_ip <= ip_mem[scan_addr];
    rd_mac <= mac_mem[scan_addr];
  end

  // Next state of the scan sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      arpc_pkg::S_IDLE: begin
        if (start_scan) begin
          state_next = arpc_pkg::S_SCAN;
        end
      end
      arpc_pkg::S_SCAN: begin
        if (hit_now) begin
          state_next = arpc_pkg::S_IDLE;
        end else if (scan_last) begin
          state_next = arpc_pkg::S_DRAIN;
        end
      end
      arpc_pkg::S_DRAIN: begin
        state_next = arpc_pkg::S_IDLE;
      end
      default: begin
        state_next = arpc_pkg::S_IDLE;
      end
    endcase
  end

  // Build the result of the job that finishes this cycle
  always_comb begin
    res_next = '0;
    res_next.status = arpc_pkg::ST_IGNORED;
    found_mac = arpc_pkg::MAC_ALL_ONES;
    res_query = job.ip;
    if (state != arpc_pkg::S_IDLE) begin
      res_query = query;
      if (hit_now) begin
        found_mac = rd_mac;
      end
    end
    if (state != arpc_pkg::S_IDLE || job.kind == arpc_pkg::K_RESOLVE) begin
      res_next.lookup_mac = found_mac;
      if (found_mac == arpc_pkg::MAC_ALL_ONES) begin
        // Miss, or a cached all-ones address: broadcast a request
        res_next.status = arpc_pkg::ST_MISS;
        res_next.send_valid = 1'b1;
        res_next.opcode = arpc_pkg::OP_REQUEST;
        res_next.sender_mac = own_mac;
        res_next.sender_ip = own_ip;
        res_next.target_mac = arpc_pkg::MAC_ALL_ONES;
        res_next.target_ip = res_query;
      end else begin
        res_next.status = arpc_pkg::ST_HIT;
      end
    end else begin
      unique case (job.kind)
        arpc_pkg::K_REPLY: begin
          res_next.status = arpc_pkg::ST_REPLIED;
          res_next.send_valid = 1'b1;
          res_next.opcode = arpc_pkg::OP_REPLY;
          res_next.sender_mac = own_mac;
          res_next.sender_ip = own_ip;
          res_next.target_mac = job.mac;
          res_next.target_ip = job.ip;
        end
        arpc_pkg::K_CACHE: begin
          res_next.status = has_room ? arpc_pkg::ST_CACHED : arpc_pkg::ST_FULL;
        end
        arpc_pkg::K_IGNORE,
        arpc_pkg::K_RESOLVE: begin
          res_next.status = arpc_pkg::ST_IGNORED;
        end
        default: begin
          res_next.status = arpc_pkg::ST_IGNORED;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arpc_pkg::S_IDLE;
      entry_count <= '0;
      scan_addr <= '0;
      rd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rd_valid <= (state == arpc_pkg::S_SCAN);
      if (cache_we) begin
        entry_count <= entry_count + arpc_pkg::CNT_W'(1);
      end
      if (state == arpc_pkg::S_SCAN) begin
        scan_addr <= scan_addr + arpc_pkg::ADDR_W'(1);
      end else begin
        scan_addr <= '0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (start_scan) begin
      query <= job.ip;
    end
    if (load) begin
      res <= res_next;
    end
  end

  // Drive the result channel
  assign rsp.valid = out_valid;
  assign rsp.status = res.status;
  assign rsp.send_valid = res.send_valid;
  assign rsp.out_opcode = res.opcode;
  assign rsp.out_sender_mac = res.sender_mac;
  assign rsp.out_sender_ip = res.sender_ip;
  assign rsp.out_target_mac = res.target_mac;
  assign rsp.out_target_ip = res.target_ip;
  assign rsp.lookup_mac = res.lookup_mac;

  assign stat.scanning = (state == arpc_pkg::S_SCAN);
  assign stat.entry_count = entry_count;
  assign stat.scan_addr = scan_addr;

endmodule

/* rtl/arp_responder_with_cache_unit.sv */
// Top level of the ARP responder with an IP-to-MAC address cache.
//
// Channels: req carries one item per transfer, either a parsed received ARP
// message or a resolve query; rsp returns exactly one result per item, in order.
// cfg_we/cfg_index/cfg_data write own_ip (index 0) and own_mac (index 1); the
// user writes them only while idle, a rule that the block itself leaves to the user.
// The front end checks and classifies each item in the cycle it is taken and
// places it in a two-entry job queue; the back end carries out the jobs.
// A received message passes through the job queue and the result register.
// A resolve walks the cache one entry per cycle through the registered read
// port of the cache memory and stops at the first hit or after the last entry;
// an empty cache gives a miss without a walk. The back end takes no new job
// until the resolve is done, while the job queue can still take items.
// Reset clears the cache fill count, the queue, the result valid flag and both
// configuration registers; cache contents need no clearing.
// When rsp stalls the result stays in its register, the back end waits, and
// req keeps taking items until the job queue is full.
module arp_responder_with_cache_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]    cfg_data,
  arpc_in_if.sink                            req,
  arpc_out_if.source                         rsp
);

  `include "arp_responder_with_cache_unit_macros.svh"

  logic [arpc_pkg::IP_W-1:0]  own_ip;
  logic [arpc_pkg::MAC_W-1:0] own_mac;
  logic                       push_valid;
  logic                       push_ready;
  arpc_pkg::job_t             push_job;
  logic                       pop_valid;
  logic                       pop_ready;
  arpc_pkg::job_t             pop_job;
  arpc_pkg::back_stat_t       stat;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip <= '0;
      own_mac <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        arpc_pkg::REG_OWN_IP: own_ip <= cfg_data[arpc_pkg::IP_W-1:0];
        arpc_pkg::REG_OWN_MAC: own_mac <= cfg_data[arpc_pkg::MAC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  arpc_front u_front (
    .own_ip     (own_ip),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  arpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  arpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .own_ip    (own_ip),
    .own_mac   (own_mac),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job       (pop_job),
    .rsp       (rsp),
    .stat      (stat)
  );

  `ARPC_ASSERT(a_count_bound, 1'b1, stat.entry_count <= arpc_pkg::CNT_W'(arpc_pkg::CACHE_ENTRIES))
  `ARPC_ASSERT(a_scan_in_range, stat.scanning, arpc_pkg::CNT_W'(stat.scan_addr) < stat.entry_count)
  `ARPC_ASSERT_NEXT(a_count_grows, 1'b1, stat.entry_count >= $past(stat.entry_count))
  `ARPC_ASSERT(a_hit_has_mac, rsp.valid && rsp.status == arpc_pkg::ST_HIT, rsp.lookup_mac != arpc_pkg::MAC_ALL_ONES)

endmodule
